FILE: design/sprt_pkg.sv
package sprt_pkg;

  localparam int TableEntriesDef = 64;
  localparam int MaxHolesDef     = 16;
  localparam logic [31:0] ThresholdReset = 32'd10000;

  // Register index of the activity threshold on the configuration port.
  localparam logic RegThreshold = 1'b0;

  typedef enum logic [3:0] {
    OP_PHASE    = 4'd0,
    OP_HEADER   = 4'd1,
    OP_BLOCK    = 4'd2,
    OP_TIP      = 4'd3,
    OP_REQUEST  = 4'd4,
    OP_RECEIVED = 4'd5,
    OP_TIMEOUT  = 4'd6,
    OP_INFLIGHT = 4'd7,
    OP_HOLES    = 4'd8,
    OP_ACTIVITY = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_IGN  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_APPLY,
    S_EMIT,
    S_HTEST,
    S_HCHECK,
    S_HPUSH,
    S_HEND
  } state_e;

  typedef struct packed {
    logic [3:0]  operation;
    logic [31:0] value;
    logic [15:0] peer_id;
    logic [4:0]  hole_count;
    logic [1:0]  new_phase;
    logic [47:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] hole_index;
    logic        hole_valid;
    logic        last;
    logic        is_outstanding;
    logic        recent;
    logic [1:0]  phase;
    logic [6:0]  outstanding_count;
    logic [31:0] received_total;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic scan_start;
    logic scan_hole;
    logic apply;
    logic emit_res;
    logic hole_init;
    logic hole_adv;
    logic hole_take;
    logic hole_push;
    logic hole_end;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [3:0] op;
    logic       scan_done;
    logic       found;
    logic       hole_more;
    logic       pend_v;
    logic       out_free;
  } sts_t;

endpackage

FILE: design/sync_progress_request_tracker_core.sv
// A beat that does not touch the request table passes through the decode, apply and
// emit states; request, receipt, timeout and inflight beats first scan the
// table one entry per cycle through its single read port.
// Holes beats scan the whole table once per candidate index and push each hole out as a beat.
// One item at a time: the next is accepted in the cycle after its result registers.
// Reset (rst_ni low, asynchronous) clears all heights, counters, phase and entry valid bits.
module sync_progress_request_tracker_core #(
  parameter int TableEntries = sprt_pkg::TableEntriesDef,
  parameter int MaxHoles     = sprt_pkg::MaxHolesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // Item input channel.
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sprt_pkg::in_t  in_data_i,
  // Result output channel; a holes query may produce several beats.
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sprt_pkg::out_t out_data_o,
  // Configuration port.
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  sprt_pkg::cmd_t cmd;
  sprt_pkg::sts_t sts;
  logic           busy;
  logic           in_accept;
  logic [31:0]    thr_q;

  // The controller is busy for the whole life of an item; the output register
  // lets the next item in while a result beat is still waiting downstream.
  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !busy;

  // The threshold register is the only configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == sprt_pkg::RegThreshold) ? thr_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= sprt_pkg::ThresholdReset;
    end else if (psel && penable && pwrite && paddr[2] == sprt_pkg::RegThreshold) begin
      thr_q <= pwdata;
    end
  end

  sprt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy)
  );

  sprt_dpath #(
    .TableEntries (TableEntries),
    .MaxHoles     (MaxHoles)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .thr_i       (thr_q),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: design/sprt_ctrl.sv
module sprt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_accept_i,
  input  sprt_pkg::sts_t    sts_i,
  output sprt_pkg::cmd_t    cmd_o,
  output logic              busy_o
);

  sprt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sprt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sprt_pkg::S_IDLE: begin
        if (in_accept_i) state_d = sprt_pkg::S_DECODE;
      end
      sprt_pkg::S_DECODE: begin
        if (sts_i.op inside {sprt_pkg::OP_REQUEST, sprt_pkg::OP_RECEIVED,
                             sprt_pkg::OP_TIMEOUT, sprt_pkg::OP_INFLIGHT}) begin
          state_d = sprt_pkg::S_SCAN;
        end else if (sts_i.op == sprt_pkg::OP_HOLES) begin
          state_d = sprt_pkg::S_HTEST;
        end else begin
          state_d = sprt_pkg::S_APPLY;
        end
      end
      sprt_pkg::S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = (sts_i.op == sprt_pkg::OP_HOLES) ? sprt_pkg::S_HCHECK : sprt_pkg::S_APPLY;
        end
      end
      sprt_pkg::S_APPLY: state_d = sprt_pkg::S_EMIT;
      sprt_pkg::S_EMIT: begin
        if (sts_i.out_free) state_d = sprt_pkg::S_IDLE;
      end
      sprt_pkg::S_HTEST: begin
        state_d = sts_i.hole_more ? sprt_pkg::S_SCAN : sprt_pkg::S_HEND;
      end
      sprt_pkg::S_HCHECK: begin
        if (!sts_i.found && sts_i.pend_v) begin
          state_d = sprt_pkg::S_HPUSH;
        end else begin
          state_d = sprt_pkg::S_HTEST;
        end
      end
      sprt_pkg::S_HPUSH: begin
        if (sts_i.out_free) state_d = sprt_pkg::S_HTEST;
      end
      sprt_pkg::S_HEND: begin
        if (sts_i.out_free) state_d = sprt_pkg::S_IDLE;
      end
      default: state_d = sprt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      sprt_pkg::S_IDLE: begin
        busy_o      = 1'b0;
        cmd_o.latch = in_accept_i;
      end
      sprt_pkg::S_DECODE: begin
        if (sts_i.op inside {sprt_pkg::OP_REQUEST, sprt_pkg::OP_RECEIVED,
                             sprt_pkg::OP_TIMEOUT, sprt_pkg::OP_INFLIGHT}) begin
          cmd_o.scan_start = 1'b1;
        end else if (sts_i.op == sprt_pkg::OP_HOLES) begin
          cmd_o.hole_init = 1'b1;
        end
      end
      sprt_pkg::S_APPLY: cmd_o.apply = 1'b1;
      sprt_pkg::S_EMIT:  cmd_o.emit_res = sts_i.out_free;
      sprt_pkg::S_HTEST: begin
        cmd_o.scan_start = sts_i.hole_more;
        cmd_o.scan_hole  = sts_i.hole_more;
      end
      sprt_pkg::S_HCHECK: begin
        // A candidate that is outstanding is skipped; a new hole is held back
        // as pending so that the final one can carry the last flag.
        if (sts_i.found) begin
          cmd_o.hole_adv = 1'b1;
        end else if (!sts_i.pend_v) begin
          cmd_o.hole_adv  = 1'b1;
          cmd_o.hole_take = 1'b1;
        end
      end
      sprt_pkg::S_HPUSH: begin
        cmd_o.hole_push = sts_i.out_free;
        cmd_o.hole_take = sts_i.out_free;
        cmd_o.hole_adv  = sts_i.out_free;
      end
      sprt_pkg::S_HEND: cmd_o.hole_end = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

FILE: design/sprt_dpath.sv
module sprt_dpath #(
  parameter int TableEntries = sprt_pkg::TableEntriesDef,
  parameter int MaxHoles     = sprt_pkg::MaxHolesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sprt_pkg::cmd_t   cmd_i,
  output sprt_pkg::sts_t   sts_o,
  input  sprt_pkg::in_t    in_data_i,
  input  logic [31:0]      thr_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output sprt_pkg::out_t   out_data_o
);

  localparam int AW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int CW = $clog2(TableEntries + 1);
  localparam int NW = $clog2(MaxHoles + 1);

  // Latched item.
  logic [3:0]  op_q;
  logic [31:0] val_q;
  logic [15:0] peer_q;
  logic [4:0]  hc_q;
  logic [1:0]  np_q;
  logic [47:0] now_q;

  // Tracker state.
  logic [1:0]  phase_q;
  logic [31:0] hdr_q, blk_q, tip_q, total_q;
  logic [47:0] last_ms_q;
  logic [CW-1:0] cnt_q;
  logic [TableEntries-1:0] valid_q;

  // Request table storage.
  logic [31:0] idx_mem [TableEntries];
  logic [15:0] peer_mem [TableEntries];
  logic [31:0] rd_idx_q;
  logic [15:0] rd_peer_q;

  // Scan engine.
  logic          issue_q, chk_q;
  logic [AW-1:0] ptr_q, chk_ptr_q;
  logic [31:0]   key_q;
  logic          found_q, free_v_q;
  logic [AW-1:0] slot_q, free_slot_q;
  logic [15:0]   fpeer_q;

  // Holes walk.
  logic [32:0]   cur_q;
  logic [31:0]   target_q, pend_q;
  logic          pend_v_q;
  logic [NW-1:0] want_q, n_q;

  // Result of a single-beat item.
  logic [1:0] res_st_q;
  logic       res_outst_q, res_rec_q;

  logic          out_valid_q;
  sprt_pkg::out_t out_q;

  logic          mem_we;
  logic          out_free;
  logic [48:0]   diff;
  logic          recent;
  logic [CW+6:0] cnt_ext;
  logic          last_addr;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign diff      = {1'b0, now_q} - {1'b0, last_ms_q};
  assign recent    = $signed(diff) < $signed({17'b0, thr_i});
  assign cnt_ext   = {7'b0, cnt_q};
  assign last_addr = (ptr_q == AW'(TableEntries - 1));
  assign mem_we    = cmd_i.apply && (op_q == sprt_pkg::OP_REQUEST) && !found_q && free_v_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= in_data_i.operation;
      val_q  <= in_data_i.value;
      peer_q <= in_data_i.peer_id;
      hc_q   <= in_data_i.hole_count;
      np_q   <= in_data_i.new_phase;
      now_q  <= in_data_i.now_ms;
    end
    if (mem_we) begin
      idx_mem[free_slot_q]  <= val_q;
      peer_mem[free_slot_q] <= peer_q;
    end
    rd_idx_q  <= idx_mem[ptr_q];
    rd_peer_q <= peer_mem[ptr_q];
  end

  // Scan: one table entry read per cycle, compared in the cycle after its read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q     <= 1'b0;
      chk_q       <= 1'b0;
      ptr_q       <= '0;
      chk_ptr_q   <= '0;
      found_q     <= 1'b0;
      free_v_q    <= 1'b0;
      key_q       <= '0;
      slot_q      <= '0;
      free_slot_q <= '0;
      fpeer_q     <= '0;
    end else begin
      chk_q     <= issue_q;
      chk_ptr_q <= ptr_q;
      if (cmd_i.scan_start) begin
        issue_q  <= 1'b1;
        ptr_q    <= '0;
        found_q  <= 1'b0;
        free_v_q <= 1'b0;
        key_q    <= cmd_i.scan_hole ? cur_q[31:0] : val_q;
      end else if (issue_q) begin
        if (last_addr) begin
          issue_q <= 1'b0;
        end else begin
          ptr_q <= ptr_q + AW'(1);
        end
      end
      if (chk_q) begin
        if (valid_q[chk_ptr_q] && rd_idx_q == key_q && !found_q) begin
          found_q <= 1'b1;
          slot_q  <= chk_ptr_q;
          fpeer_q <= rd_peer_q;
        end
        if (!valid_q[chk_ptr_q] && !free_v_q) begin
          free_v_q    <= 1'b1;
          free_slot_q <= chk_ptr_q;
        end
      end
    end
  end

  // Tracker state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      hdr_q     <= '0;
      blk_q     <= '0;
      tip_q     <= '0;
      total_q   <= '0;
      last_ms_q <= '0;
      cnt_q     <= '0;
      valid_q   <= '0;
    end else if (cmd_i.apply) begin
      case (op_q)
        sprt_pkg::OP_PHASE:  if (np_q > phase_q) phase_q <= np_q;
        sprt_pkg::OP_HEADER: if (val_q > hdr_q) hdr_q <= val_q;
        sprt_pkg::OP_BLOCK: begin
          if (val_q > blk_q) begin
            blk_q     <= val_q;
            last_ms_q <= now_q;
          end
        end
        sprt_pkg::OP_TIP:    if (val_q > tip_q) tip_q <= val_q;
        sprt_pkg::OP_REQUEST: begin
          if (mem_we) begin
            valid_q[free_slot_q] <= 1'b1;
            cnt_q <= cnt_q + CW'(1);
          end
        end
        sprt_pkg::OP_RECEIVED: begin
          if (found_q) begin
            valid_q[slot_q] <= 1'b0;
            cnt_q <= cnt_q - CW'(1);
          end
          total_q   <= total_q + 32'd1;
          last_ms_q <= now_q;
        end
        sprt_pkg::OP_TIMEOUT: begin
          if (found_q && fpeer_q == peer_q) begin
            valid_q[slot_q] <= 1'b0;
            cnt_q <= cnt_q - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      res_outst_q <= 1'b0;
      res_rec_q   <= 1'b0;
      res_st_q    <= sprt_pkg::ST_IGN;
      case (op_q)
        sprt_pkg::OP_PHASE:  if (np_q > phase_q) res_st_q <= sprt_pkg::ST_OK;
        sprt_pkg::OP_HEADER: if (val_q > hdr_q) res_st_q <= sprt_pkg::ST_OK;
        sprt_pkg::OP_BLOCK:  if (val_q > blk_q) res_st_q <= sprt_pkg::ST_OK;
        sprt_pkg::OP_TIP:    if (val_q > tip_q) res_st_q <= sprt_pkg::ST_OK;
        sprt_pkg::OP_REQUEST: begin
          if (found_q) begin
            res_st_q <= sprt_pkg::ST_DUP;
          end else if (free_v_q) begin
            res_st_q <= sprt_pkg::ST_OK;
          end else begin
            res_st_q <= sprt_pkg::ST_FULL;
          end
        end
        sprt_pkg::OP_RECEIVED: res_st_q <= sprt_pkg::ST_OK;
        sprt_pkg::OP_TIMEOUT: begin
          if (found_q && fpeer_q == peer_q) res_st_q <= sprt_pkg::ST_OK;
        end
        sprt_pkg::OP_INFLIGHT: begin
          res_st_q    <= sprt_pkg::ST_OK;
          res_outst_q <= found_q;
        end
        sprt_pkg::OP_ACTIVITY: begin
          res_st_q  <= sprt_pkg::ST_OK;
          res_rec_q <= recent;
        end
        default: ;
      endcase
    end
  end

  // Holes walk over the candidate range.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      n_q      <= '0;
      cur_q    <= '0;
      target_q <= '0;
      want_q   <= '0;
      pend_q   <= '0;
    end else begin
      if (cmd_i.hole_init) begin
        cur_q    <= {1'b0, blk_q} + 33'd1;
        target_q <= (hdr_q < tip_q) ? hdr_q : tip_q;
        want_q   <= (int'(hc_q) > MaxHoles) ? NW'(MaxHoles) : NW'(hc_q);
        n_q      <= '0;
        pend_v_q <= 1'b0;
      end
      if (cmd_i.hole_take) begin
        pend_q   <= cur_q[31:0];
        pend_v_q <= 1'b1;
        n_q      <= n_q + NW'(1);
      end
      if (cmd_i.hole_adv) cur_q <= cur_q + 33'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_res || cmd_i.hole_push || cmd_i.hole_end) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_res || cmd_i.hole_push || cmd_i.hole_end) begin
      out_q.phase             <= phase_q;
      out_q.outstanding_count <= cnt_ext[6:0];
      out_q.received_total    <= total_q;
      out_q.status            <= cmd_i.emit_res ? res_st_q : sprt_pkg::ST_OK;
      out_q.is_outstanding    <= cmd_i.emit_res && res_outst_q;
      out_q.recent            <= cmd_i.emit_res && res_rec_q;
      out_q.last              <= !cmd_i.hole_push;
      out_q.hole_valid        <= cmd_i.hole_push || (cmd_i.hole_end && pend_v_q);
      out_q.hole_index        <= (cmd_i.hole_push || (cmd_i.hole_end && pend_v_q)) ?
                                 pend_q : 32'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    sts_o.op        = op_q;
    sts_o.scan_done = chk_q && (chk_ptr_q == AW'(TableEntries - 1));
    sts_o.found     = found_q;
    sts_o.hole_more = (n_q < want_q) && (cur_q <= {1'b0, target_q});
    sts_o.pend_v    = pend_v_q;
    sts_o.out_free  = out_free;
  end

endmodule

FILE: design/sprt_checker.sv
module sprt_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input sprt_pkg::out_t out_data_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted while previous item still in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hole_valid |-> out_data_o.last)
    else $error("non-hole beat without last");

  a_hole_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hole_valid |->
      out_data_o.status == sprt_pkg::ST_OK && !out_data_o.is_outstanding && !out_data_o.recent)
    else $error("hole beat carries foreign fields");

endmodule

bind sync_progress_request_tracker_core sprt_checker u_sprt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

FILE: tb/sprt_progress_checker.sv
module sprt_progress_checker
  import sprt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_data_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatch_count,
  output int          beats_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Entries = TableEntriesDef;
  localparam int Holes   = MaxHolesDef;

  // Shadow of the tracker state.
  logic [1:0]  phase_q;
  logic [31:0] header_q;
  logic [31:0] block_q;
  logic [31:0] tip_q;
  logic [47:0] last_rx_q;
  logic [31:0] rx_total_q;
  logic [31:0] threshold_q;
  bit          slot_used[Entries];
  logic [31:0] slot_idx[Entries];
  logic [15:0] slot_peer[Entries];

  out_t expected_beats[$];

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic int lookup(input logic [32:0] idx);
    for (int i = 0; i < Entries; i++) begin
      if (slot_used[i] && {1'b0, slot_idx[i]} == idx) return i;
    end
    return -1;
  endfunction

  function automatic logic [6:0] used_count();
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < Entries; i++) n += 7'(slot_used[i]);
    return n;
  endfunction

  task automatic queue_beat(input logic [1:0] st, input logic [31:0] hidx, input logic hval,
                            input logic lst, input logic outst, input logic rec);
    out_t b;
    b.status            = st;
    b.hole_index        = hidx;
    b.hole_valid        = hval;
    b.last              = lst;
    b.is_outstanding    = outst;
    b.recent            = rec;
    b.phase             = phase_q;
    b.outstanding_count = used_count();
    b.received_total    = rx_total_q;
    expected_beats = {expected_beats, b};
  endtask

  // Applies one accepted item to the shadow state and queues its result beats.
  task automatic predict_beats(input in_t d);
    logic [1:0]  st;
    int          slot;
    int          want;
    logic [32:0] cur;
    logic [32:0] target;
    logic [31:0] found[$];
    longint      diff;
    st = ST_IGN;
    case (d.operation)
      OP_PHASE: if (d.new_phase > phase_q) begin
        phase_q = d.new_phase;
        st = ST_OK;
      end
      OP_HEADER: if (d.value > header_q) begin
        header_q = d.value;
        st = ST_OK;
      end
      OP_BLOCK: if (d.value > block_q) begin
        block_q = d.value;
        last_rx_q = d.now_ms;
        st = ST_OK;
      end
      OP_TIP: if (d.value > tip_q) begin
        tip_q = d.value;
        st = ST_OK;
      end
      OP_REQUEST: begin
        if (lookup({1'b0, d.value}) >= 0) begin
          st = ST_DUP;
        end else begin
          st = ST_FULL;
          for (int i = 0; i < Entries; i++) begin
            if (!slot_used[i]) begin
              slot_used[i] = 1'b1;
              slot_idx[i]  = d.value;
              slot_peer[i] = d.peer_id;
              st = ST_OK;
              break;
            end
          end
        end
      end
      OP_RECEIVED: begin
        slot = lookup({1'b0, d.value});
        if (slot >= 0) slot_used[slot] = 1'b0;
        rx_total_q = rx_total_q + 32'd1;
        last_rx_q = d.now_ms;
        st = ST_OK;
      end
      OP_TIMEOUT: begin
        slot = lookup({1'b0, d.value});
        if (slot >= 0 && slot_peer[slot] == d.peer_id) begin
          slot_used[slot] = 1'b0;
          st = ST_OK;
        end
      end
      OP_INFLIGHT: begin
        queue_beat(ST_OK, '0, 1'b0, 1'b1, lookup({1'b0, d.value}) >= 0, 1'b0);
        return;
      end
      OP_HOLES: begin
        want   = (d.hole_count > Holes) ? Holes : int'(d.hole_count);
        cur    = {1'b0, block_q} + 33'd1;
        target = {1'b0, (header_q < tip_q) ? header_q : tip_q};
        while (found.size() < want && cur <= target) begin
          if (lookup(cur) < 0) found = {found, cur[31:0]};
          cur++;
        end
        if (found.size() == 0) begin
          queue_beat(ST_OK, '0, 1'b0, 1'b1, 1'b0, 1'b0);
        end else begin
          foreach (found[k]) queue_beat(ST_OK, found[k], 1'b1, k == found.size() - 1, 1'b0, 1'b0);
        end
        return;
      end
      OP_ACTIVITY: begin
        // Signed difference, so a time before the last receipt reads as recent.
        diff = longint'({16'b0, d.now_ms}) - longint'({16'b0, last_rx_q});
        queue_beat(ST_OK, '0, 1'b0, 1'b1, 1'b0, diff < longint'({32'b0, threshold_q}));
        return;
      end
      default: ;
    endcase
    queue_beat(st, '0, 1'b0, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] exp);
    if (got !== exp) report_mismatch($sformatf("%s got %0h expected %0h", name, got, exp));
  endtask

  initial begin
    mismatch_count = 0;
    beats_pending  = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_t e;
    if (!rst_ni) begin
      phase_q     = '0;
      header_q    = '0;
      block_q     = '0;
      tip_q       = '0;
      last_rx_q   = '0;
      rx_total_q  = '0;
      threshold_q = ThresholdReset;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      expected_beats.delete();
      beats_pending = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == {RegThreshold, 2'b00})
        threshold_q = pwdata;
      // Old beats are checked before the new item is predicted.
      if (out_valid_i && !out_stall_i) begin
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat %h", out_data_i));
        end else begin
          e = expected_beats.pop_front();
          check_field("status", out_data_i.status, e.status);
          check_field("hole_index", out_data_i.hole_index, e.hole_index);
          check_field("hole_valid", out_data_i.hole_valid, e.hole_valid);
          check_field("last", out_data_i.last, e.last);
          check_field("is_outstanding", out_data_i.is_outstanding, e.is_outstanding);
          check_field("recent", out_data_i.recent, e.recent);
          check_field("phase", out_data_i.phase, e.phase);
          check_field("outstanding_count", out_data_i.outstanding_count, e.outstanding_count);
          check_field("received_total", out_data_i.received_total, e.received_total);
        end
      end
      if (in_valid_i && !in_stall_i) predict_beats(in_data_i);
      beats_pending = expected_beats.size();
    end
  end

endmodule

FILE: tb/sync_progress_request_tracker_core_test.sv
// Stimulus and verdict for the sync progress tracker. The checker beside the
// block predicts every result beat; this module only drives traffic and reports.
module sync_progress_request_tracker_core_test;
  import sprt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  out_t        out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatch_count;
  int beats_pending;

  // Set by the stimulus once; the receiver then holds off for a long stretch.
  bit long_hold = 1'b0;
  // Sender runs without gaps while this is set.
  bit send_quiet = 1'b0;

  // Rough view of the heights and of what was requested, used only to aim the
  // random items at interesting indices. The checker holds the exact state.
  logic [31:0] hdr_base = 32'd100;
  logic [31:0] blk_base = 32'd10;
  logic [47:0] clock_ms = 48'd1000;
  logic [31:0] asked_idx[$];
  logic [15:0] asked_peer[$];

  sync_progress_request_tracker_core u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sprt_progress_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatch_count, .beats_pending
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // The whole run fits well inside this bound; reaching it means a hang.
  initial begin
    #80ms;
    $display("sync_progress_request_tracker_core_test NOT OK");
    $finish;
  end

  // Receiver: a random hold-off before every beat, with gap-free stretches,
  // and one long hold-off that lets the block back up into its input.
  initial begin
    int n;
    int beat_no;
    beat_no = 0;
    @(negedge clk_i);
    forever begin
      if (long_hold) begin
        n = 600;
        long_hold = 1'b0;
      end else if ((beat_no / 40) % 3 == 1) begin
        n = 0;
      end else begin
        n = $urandom_range(0, 15);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      beat_no++;
      @(negedge clk_i);
    end
  end

  function automatic in_t item(input logic [3:0] op, input logic [31:0] v,
                               input logic [15:0] p, input logic [4:0] hc,
                               input logic [1:0] np, input logic [47:0] now);
    in_t d;
    d.operation  = op;
    d.value      = v;
    d.peer_id    = p;
    d.hole_count = hc;
    d.new_phase  = np;
    d.now_ms     = now;
    return d;
  endfunction

  // Offers one item after a random gap and holds it until the block takes it.
  // Called and returning at a falling edge.
  task automatic offer_item(input in_t d);
    int n;
    n = send_quiet ? 0 : $urandom_range(0, 15);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Waits for every predicted beat, then lets the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (beats_pending != 0);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [31:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {RegThreshold, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [47:0] rand48();
    return {$urandom, $urandom};
  endfunction

  // One random item, weighted toward sequences that walk the table: requests
  // in the window above the block height, then receipts and timeouts of them.
  task automatic random_item();
    int          r;
    int          k;
    logic [31:0] v;
    logic [15:0] p;
    logic [4:0]  hc;
    logic [3:0]  op;
    r  = $urandom_range(0, 99);
    p  = 16'($urandom);
    hc = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 6));
    clock_ms += 48'($urandom_range(0, 3000));
    v  = $urandom;
    op = OP_ACTIVITY;
    if (r < 8) begin
      op = OP_PHASE;
    end else if (r < 16) begin
      op = OP_HEADER;
      hdr_base += 32'($urandom_range(0, 30));
      v = ($urandom_range(0, 4) == 0) ? hdr_base - 32'd40 : hdr_base;
    end else if (r < 22) begin
      op = OP_BLOCK;
      if (blk_base + 32'd20 < hdr_base) blk_base += 32'($urandom_range(0, 4));
      v = ($urandom_range(0, 4) == 0) ? blk_base - 32'd3 : blk_base;
    end else if (r < 28) begin
      op = OP_TIP;
      v = hdr_base + 32'($urandom_range(0, 20)) - 32'd10;
    end else if (r < 48) begin
      op = OP_REQUEST;
      if ($urandom_range(0, 9) != 0) v = blk_base + 32'($urandom_range(1, 60));
      asked_idx  = {asked_idx, v};
      asked_peer = {asked_peer, p};
    end else if (r < 62 || (r < 70 && asked_idx.size() > 0)) begin
      op = (r < 62) ? OP_RECEIVED : OP_TIMEOUT;
      if (asked_idx.size() > 0 && $urandom_range(0, 5) != 0) begin
        k = $urandom_range(0, asked_idx.size() - 1);
        v = asked_idx[k];
        if (op == OP_RECEIVED || $urandom_range(0, 2) != 0) p = asked_peer[k];
        asked_idx.delete(k);
        asked_peer.delete(k);
      end
    end else if (r < 78) begin
      op = OP_INFLIGHT;
      if (asked_idx.size() > 0 && $urandom_range(0, 1) == 0)
        v = asked_idx[$urandom_range(0, asked_idx.size() - 1)];
    end else if (r < 90) begin
      op = OP_HOLES;
    end else if (r < 96) begin
      op = OP_ACTIVITY;
    end else begin
      op = 4'($urandom_range(10, 15));
    end
    offer_item(item(op, v, p, hc, 2'($urandom),
                    ($urandom_range(0, 9) == 0) ? rand48() : clock_ms));
  endtask

  initial begin
    logic [31:0] fill_tag;
    // Held in reset, then released at a falling edge.
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_threshold(32'hFFFF_FFFF);

    // Directed part: rising values with and without change, duplicate request,
    // timeout by the wrong peer and by the right one, receipt of an index that
    // was never requested, holes with zero, normal and clamped counts, activity
    // with a time before the last receipt, and unknown operation codes.
    offer_item(item(OP_PHASE,    32'd0,   16'h0000, 5'd0,  2'd1, 48'd0));
    offer_item(item(OP_PHASE,    32'd0,   16'h0000, 5'd0,  2'd0, 48'd0));
    offer_item(item(OP_HEADER,   32'd100, 16'h0000, 5'd0,  2'd0, 48'd0));
    offer_item(item(OP_HEADER,   32'd50,  16'h0000, 5'd0,  2'd0, 48'd0));
    offer_item(item(OP_TIP,      32'd80,  16'h0000, 5'd0,  2'd0, 48'd0));
    offer_item(item(OP_BLOCK,    32'd10,  16'h0000, 5'd0,  2'd0, 48'd5000));
    offer_item(item(OP_REQUEST,  32'd12,  16'd7,    5'd0,  2'd0, 48'd0));
    offer_item(item(OP_REQUEST,  32'd12,  16'd9,    5'd0,  2'd0, 48'd0));
    offer_item(item(OP_REQUEST,  32'd0,   16'hFFFF, 5'd0,  2'd0, 48'd0));
    offer_item(item(OP_INFLIGHT, 32'd12,  16'h0000, 5'd0,  2'd0, 48'd0));
    offer_item(item(OP_INFLIGHT, 32'd13,  16'h0000, 5'd0,  2'd0, 48'd0));
    offer_item(item(OP_HOLES,    32'd0,   16'h0000, 5'd5,  2'd0, 48'd0));
    offer_item(item(OP_HOLES,    32'd0,   16'h0000, 5'd0,  2'd0, 48'd0));
    offer_item(item(OP_HOLES,    32'd0,   16'h0000, 5'd31, 2'd0, 48'd0));
    offer_item(item(OP_TIMEOUT,  32'd12,  16'd8,    5'd0,  2'd0, 48'd0));
    offer_item(item(OP_TIMEOUT,  32'd12,  16'd7,    5'd0,  2'd0, 48'd0));
    offer_item(item(OP_RECEIVED, 32'd0,   16'h0000, 5'd0,  2'd0, 48'd6000));
    offer_item(item(OP_RECEIVED, 32'd999, 16'h0000, 5'd0,  2'd0, 48'd6500));
    offer_item(item(OP_ACTIVITY, 32'd0,   16'h0000, 5'd0,  2'd0, 48'd7000));
    offer_item(item(OP_ACTIVITY, 32'd0,   16'h0000, 5'd0,  2'd0, 48'd0));
    offer_item(item(OP_ACTIVITY, 32'hFFFF_FFFF, 16'hFFFF, 5'h1F, 2'd3, 48'hFFFF_FFFF_FFFF));
    offer_item(item(4'd15,       32'hFFFF_FFFF, 16'hFFFF, 5'h1F, 2'd3, 48'hFFFF_FFFF_FFFF));
    offer_item(item(4'd10,       32'd0,   16'h0000, 5'd0,  2'd0, 48'd0));
    drain();

    // A zero window: only a time before the last receipt is recent.
    write_threshold(32'd0);
    for (int i = 0; i < 20; i++) begin
      send_quiet = ((i / 15) % 2 == 1);
      random_item();
    end
    drain();

    // Fill the table to the brim and past it while the receiver backs up.
    write_threshold($urandom);
    send_quiet = 1'b0;
    fill_tag = {$urandom_range(1, 255), 24'h0};
    for (int i = 0; i < TableEntriesDef + 3; i++) begin
      if (i == 10) long_hold = 1'b1;
      offer_item(item(OP_REQUEST, fill_tag | 32'(i), 16'($urandom), 5'($urandom),
                      2'($urandom), rand48()));
    end
    offer_item(item(OP_REQUEST, fill_tag | 32'd5, 16'($urandom), 5'd0, 2'd0, 48'd0));
    for (int i = 0; i < 40; i++) begin
      offer_item(item(($urandom_range(0, 3) == 0) ? OP_TIMEOUT : OP_RECEIVED,
                      fill_tag | 32'($urandom_range(0, TableEntriesDef - 1)),
                      16'($urandom), 5'($urandom), 2'($urandom), rand48()));
    end
    drain();

    write_threshold(ThresholdReset);
    for (int i = 0; i < 20; i++) begin
      send_quiet = ((i / 6) % 3 == 2);
      random_item();
    end
    drain();

    // Heights at their top value: no candidate lies above the block height.
    write_threshold(32'd1);
    send_quiet = 1'b0;
    offer_item(item(OP_PHASE,    32'd0, 16'd0, 5'd0,  2'd3, 48'd0));
    offer_item(item(OP_HEADER,   32'hFFFF_FFFF, 16'd0, 5'd0, 2'd0, 48'd0));
    offer_item(item(OP_TIP,      32'hFFFF_FFFF, 16'd0, 5'd0, 2'd0, 48'd0));
    offer_item(item(OP_BLOCK,    32'hFFFF_FFFF, 16'd0, 5'd0, 2'd0, 48'hFFFF_FFFF_FFFF));
    offer_item(item(OP_HOLES,    32'd0, 16'd0, 5'd16, 2'd0, 48'd0));
    offer_item(item(OP_ACTIVITY, 32'd0, 16'd0, 5'd0,  2'd0, 48'hFFFF_FFFF_FFFF));
    offer_item(item(OP_ACTIVITY, 32'd0, 16'd0, 5'd0,  2'd0, 48'hFFFF_FFFF_FFFE));
    drain();

    if (mismatch_count == 0) begin
      $display("sync_progress_request_tracker_core_test OK");
    end else begin
      $display("sync_progress_request_tracker_core_test NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/sprt_pkg.sv
design/sprt_ctrl.sv
design/sprt_dpath.sv
design/sync_progress_request_tracker_core.sv
design/sprt_checker.sv
tb/sprt_progress_checker.sv
tb/sync_progress_request_tracker_core_test.sv
